FILE: design/tcw_pkg.sv
package tcw_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // field widths fixed by the interface
  localparam int CHAR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int CELL_W  = 16;
  localparam int ATTR_W  = 8;

  // wide enough for row * columns + column at the largest screen
  localparam int LIN_W  = 13;
  // column arithmetic, holds the last column plus a tab step
  localparam int CALC_W = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic capture;
    logic clear_step;
    logic put;
    logic read;
    logic scroll_step;
    logic cnt_clr;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic cmd_in;
    logic need_scroll;
    logic clear_end;
    logic scroll_end;
  } tcw_stat_t;

endpackage

FILE: design/text_console_writer.sv
// Text console engine: put-character commands move a cursor and write cells of
// attribute and character into a COLUMNS x ROWS screen memory, read commands
// return one cell. After reset the screen memory is cleared one cell a cycle,
// and no transfer is taken until that ends. A read or a put that does not
// scroll goes from capture through the read or put step to the done step,
// which loads the output register; a put that runs past the last row first
// scrolls the screen through the copy loop. One item is worked at a time,
// and the next is taken while a finished result waits in the output register.
// The attribute attr (reset 0x0f) is written through cfg_we/cfg_wdata.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]  read_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcw_pkg::INDEX_W-1:0]  cursor_location,
  output logic [tcw_pkg::CELL_W-1:0]   cell_value,
  output logic                         scrolled
);

  tcw_pkg::tcw_cmd_t  ctl;
  tcw_pkg::tcw_stat_t st;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (ctl)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (ctl),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd_in          (cmd),
    .char_code       (char_code),
    .read_index      (read_index),
    .cursor_location (cursor_location),
    .cell_value      (cell_value),
    .scrolled        (scrolled)
  );

endmodule

FILE: design/tcw_ctrl.sv
module tcw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tcw_pkg::tcw_stat_t st,
  output tcw_pkg::tcw_cmd_t  cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PUT    = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_end) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = (st.cmd_in == tcw_pkg::CMD_READ) ? ST_READ : ST_PUT;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_DONE;
      end
      ST_PUT: begin
        cmd.put = 1'b1;
        if (st.need_scroll) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_SCROLL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (st.scroll_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        // the output register is free or is being emptied by this transfer
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  a_scroll_follows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT && st.need_scroll) |=> (state == ST_SCROLL))
    else $error("scroll not started after wrap past last row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled result");

  a_scroll_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCROLL && st.scroll_end) |=>
      (state == ST_DONE && out_valid == $past(out_valid && out_stall)))
    else $error("scroll did not finish into result stage");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_PUT || state == ST_READ))
    else $error("accepted transfer not executed");

endmodule

FILE: design/tcw_datapath.sv
module tcw_datapath #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tcw_pkg::tcw_cmd_t            cmd,
  output tcw_pkg::tcw_stat_t           st,
  input  logic                         cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_wdata,
  input  logic                         cmd_in,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::INDEX_W-1:0]  read_index,
  output logic [tcw_pkg::INDEX_W-1:0]  cursor_location,
  output logic [tcw_pkg::CELL_W-1:0]   cell_value,
  output logic                         scrolled
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int LW         = tcw_pkg::LIN_W;
  localparam int CW         = tcw_pkg::CALC_W;

  logic [tcw_pkg::CELL_W-1:0] screen [CELL_COUNT];
  logic [tcw_pkg::CELL_W-1:0] rd_data;
  logic                       mem_we;
  logic                       mem_re;
  logic [AW-1:0]              mem_wa;
  logic [AW-1:0]              mem_ra;
  logic [tcw_pkg::CELL_W-1:0] mem_wd;

  logic [tcw_pkg::ATTR_W-1:0]  attr;
  logic [COL_W-1:0]            col;
  logic [ROW_W-1:0]            row;
  logic [CNT_W-1:0]            cnt;
  logic                        cmd_q;
  logic [tcw_pkg::CHAR_W-1:0]  ch_q;
  logic [tcw_pkg::INDEX_W-1:0] idx_q;
  logic                        range_q;
  logic                        scroll_q;

  logic [tcw_pkg::CELL_W-1:0] blank;
  logic [LW-1:0]              lin;
  logic                       printable;
  logic                       bs_write;
  logic [CW-1:0]              col_ext;
  logic [CW-1:0]              tab_sum;
  logic [CW-1:0]              col_calc;
  logic                       line_feed;
  logic                       wrap;
  logic                       row_step;
  logic [CNT_W-1:0]           cnt_prev;

  assign blank     = {attr, tcw_pkg::CH_SPACE};
  assign lin       = LW'(row) * LW'(COLUMNS) + LW'(col);
  assign printable = !ch_q[7] && (ch_q[6] || ch_q[5]);
  assign bs_write  = (ch_q == tcw_pkg::CH_BS) && (col != '0);
  assign col_ext   = CW'(col);
  assign tab_sum   = col_ext + CW'(8);
  assign line_feed = (ch_q == tcw_pkg::CH_LF);
  assign cnt_prev  = cnt - CNT_W'(1);

  always_comb begin
    col_calc = col_ext;
    if (ch_q == tcw_pkg::CH_BS) begin
      if (col != '0) col_calc = col_ext - CW'(1);
    end else if (ch_q == tcw_pkg::CH_TAB) begin
      col_calc = {tab_sum[CW-1:3], 3'b000};
    end else if (ch_q == tcw_pkg::CH_CR || line_feed) begin
      col_calc = '0;
    end else if (printable) begin
      col_calc = col_ext + CW'(1);
    end
  end

  assign wrap     = (col_calc >= CW'(COLUMNS));
  assign row_step = line_feed || wrap;

  assign st.cmd_in      = cmd_in;
  assign st.need_scroll = row_step && (row == ROW_W'(ROWS - 1));
  assign st.clear_end   = (cnt == CNT_W'(CELL_COUNT - 1));
  assign st.scroll_end  = (cnt == CNT_W'(CELL_COUNT));

  // write and read port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    if (cmd.clear_step) begin
      mem_we = 1'b1;
      mem_wa = AW'(cnt);
    end else if (cmd.put) begin
      mem_we = printable || bs_write;
      mem_wa = printable ? AW'(lin) : AW'(lin - LW'(1));
      mem_wd = printable ? {attr, ch_q} : blank;
    end else if (cmd.scroll_step) begin
      // write uses the registered read data of the cycle before: cell k takes what was read at k + columns
      mem_we = (cnt != '0);
      mem_wa = AW'(cnt_prev);
      mem_wd = (cnt <= CNT_W'(MOVE_COUNT)) ? rd_data : blank;
      mem_re = (cnt < CNT_W'(MOVE_COUNT));
      mem_ra = AW'(cnt + CNT_W'(COLUMNS));
    end else if (cmd.read) begin
      mem_re = range_q;
      mem_ra = AW'(idx_q);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) screen[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= screen[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attr <= tcw_pkg::ATTR_RESET;
      col  <= '0;
      row  <= '0;
      cnt  <= '0;
    end else begin
      if (cfg_we) attr <= cfg_wdata;
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.clear_step || cmd.scroll_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.put) begin
        col <= wrap ? '0 : COL_W'(col_calc);
        if (row_step && !st.need_scroll) row <= row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q    <= cmd_in;
      ch_q     <= char_code;
      idx_q    <= read_index;
      range_q  <= (LW'(read_index) < LW'(CELL_COUNT));
      scroll_q <= 1'b0;
    end else if (cmd.put) begin
      scroll_q <= st.need_scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cursor_location <= lin[tcw_pkg::INDEX_W-1:0];
      cell_value      <= (cmd_q == tcw_pkg::CMD_READ && range_q) ? rd_data : '0;
      scrolled        <= scroll_q;
    end
  end

endmodule
